### rtl/bmsi_pkg.sv
// ----------------------------------------------------------------------------
// bmsi_pkg
// Widths, codes and shared types of the bank mapper with scanline IRQ.
// ----------------------------------------------------------------------------
package bmsi_pkg;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int TGT_W      = 3;
    localparam int MADDR_W    = 19;
    localparam int PRG_BANK_W = 6;
    localparam int CHR_BANK_W = 8;
    localparam int WIN_W      = 13;
    localparam int CHR_OFS_W  = 10;

    localparam int SOUND_REGS     = 64;
    localparam int CHR_BANK_COUNT = 8;
    localparam int SND_IDX_W      = $clog2(SOUND_REGS);
    localparam int CHR_IDX_W      = $clog2(CHR_BANK_COUNT);

    localparam logic [CMD_W-1:0] CMD_CPU_RD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CPU_WR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_VID_RD = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

    localparam logic [TGT_W-1:0] TGT_NONE  = 3'd0;
    localparam logic [TGT_W-1:0] TGT_WRAM  = 3'd1;
    localparam logic [TGT_W-1:0] TGT_PRG   = 3'd2;
    localparam logic [TGT_W-1:0] TGT_CHR   = 3'd3;
    localparam logic [TGT_W-1:0] TGT_SOUND = 3'd4;

    localparam logic [ADDR_W-1:0] REG_MASK    = 16'hF010;
    localparam logic [ADDR_W-1:0] SND_MASK    = 16'hF030;
    localparam logic [ADDR_W-1:0] SND_DATA    = 16'h9030;
    localparam logic [ADDR_W-1:0] REG_PRG0    = 16'h8000;
    localparam logic [ADDR_W-1:0] REG_PRG1    = 16'h8010;
    localparam logic [ADDR_W-1:0] REG_PRG2    = 16'h9000;
    localparam logic [ADDR_W-1:0] REG_SND_IDX = 16'h9010;
    localparam logic [ADDR_W-1:0] REG_CHR_A0  = 16'hA000;
    localparam logic [ADDR_W-1:0] REG_CHR_A1  = 16'hA010;
    localparam logic [ADDR_W-1:0] REG_CHR_B0  = 16'hB000;
    localparam logic [ADDR_W-1:0] REG_CHR_B1  = 16'hB010;
    localparam logic [ADDR_W-1:0] REG_CHR_C0  = 16'hC000;
    localparam logic [ADDR_W-1:0] REG_CHR_C1  = 16'hC010;
    localparam logic [ADDR_W-1:0] REG_CHR_D0  = 16'hD000;
    localparam logic [ADDR_W-1:0] REG_CHR_D1  = 16'hD010;
    localparam logic [ADDR_W-1:0] REG_IRQ_RLD = 16'hE000;
    localparam logic [ADDR_W-1:0] REG_IRQ_CTL = 16'hE010;
    localparam logic [ADDR_W-1:0] REG_IRQ_ACK = 16'hF000;

    localparam logic [3:0] CHR_REG_BASE = 4'hA;
    localparam int         IRQ_EN_BIT   = 1;

    localparam logic [PRG_BANK_W-1:0] LAST_PRG_RST = 6'd63;
    localparam logic [DATA_W-1:0]     IRQ_CNT_TOP  = 8'hFF;

    typedef struct packed {
        logic [TGT_W-1:0]      tgt;
        logic                  wr;
        logic [MADDR_W-1:0]    maddr;
        logic [DATA_W-1:0]     wdata;
        logic                  prg_rd;
        logic [1:0]            prg_slot;
        logic                  chr_rd;
        logic [CHR_IDX_W-1:0]  chr_ridx;
        logic [CHR_OFS_W-1:0]  chr_ofs;
        logic                  snd_wr;
        logic [2:0]            prg_we;
        logic                  snd_idx_we;
        logic                  chr_we;
        logic [CHR_IDX_W-1:0]  chr_widx;
        logic                  irq_rld_we;
        logic                  irq_ctl_we;
        logic                  irq_ack;
        logic                  tick;
    } t_dec;

    typedef struct packed {
        logic [TGT_W-1:0]      tgt;
        logic                  wr;
        logic [MADDR_W-1:0]    maddr;
        logic [DATA_W-1:0]     wdata;
        logic                  irq;
        logic                  chr_rd;
        logic [CHR_IDX_W-1:0]  chr_idx;
        logic [CHR_OFS_W-1:0]  chr_ofs;
    } t_mid;

    typedef struct packed {
        logic [TGT_W-1:0]      tgt;
        logic                  wr;
        logic [MADDR_W-1:0]    maddr;
        logic [DATA_W-1:0]     wdata;
        logic                  irq;
    } t_res;

endpackage

### rtl/bmsi_in_if.sv
// ----------------------------------------------------------------------------
// bmsi_in_if
// Bus access channel: command, address and write byte.
// ----------------------------------------------------------------------------
interface bmsi_in_if import bmsi_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] bus_addr;
    logic [DATA_W-1:0] bus_wdata;

    modport source (output valid, cmd, bus_addr, bus_wdata, input ready);
    modport sink   (input valid, cmd, bus_addr, bus_wdata, output ready);
endinterface

### rtl/bmsi_out_if.sv
// ----------------------------------------------------------------------------
// bmsi_out_if
// Result channel: translated target, address, write byte and IRQ line.
// ----------------------------------------------------------------------------
interface bmsi_out_if import bmsi_pkg::*;;
    logic               valid;
    logic               ready;
    logic [TGT_W-1:0]   target;
    logic               is_write;
    logic [MADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0]  mem_wdata;
    logic               irq;

    modport source (output valid, target, is_write, mem_addr, mem_wdata, irq,
                    input ready);
    modport sink   (input valid, target, is_write, mem_addr, mem_wdata, irq,
                    output ready);
endinterface

### rtl/bmsi_cfg_if.sv
// ----------------------------------------------------------------------------
// bmsi_cfg_if
// Configuration write channel for the fixed last program bank.
// ----------------------------------------------------------------------------
interface bmsi_cfg_if import bmsi_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [PRG_BANK_W-1:0] last_prg_bank;

    modport source (output valid, last_prg_bank, input ready);
    modport sink   (input valid, last_prg_bank, output ready);
endinterface

### rtl/bmsi_decode.sv
// ----------------------------------------------------------------------------
// bmsi_decode
// Address decode of one bus word into target, window and register strobes.
// ----------------------------------------------------------------------------
module bmsi_decode import bmsi_pkg::*; (
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output t_dec              o_dec
);

    logic [3:0]        w_chr_row;
    logic [ADDR_W-1:0] w_sel;
    logic              w_wram;

    assign w_chr_row = i_addr[15:12] - CHR_REG_BASE;
    assign w_sel     = i_addr & REG_MASK;
    assign w_wram    = (i_addr[15:13] == 3'b011);

    always_comb begin
        o_dec          = '0;
        o_dec.prg_slot = i_addr[14:13];
        o_dec.chr_ridx = i_addr[CHR_OFS_W+CHR_IDX_W-1:CHR_OFS_W];
        o_dec.chr_ofs  = i_addr[CHR_OFS_W-1:0];
        o_dec.chr_widx = {w_chr_row[1:0], i_addr[4]};
        case (i_cmd)
            CMD_CPU_RD: begin
                if (w_wram) begin
                    o_dec.tgt   = TGT_WRAM;
                    o_dec.maddr = MADDR_W'(i_addr[WIN_W-1:0]);
                end else if (i_addr[15]) begin
                    o_dec.tgt    = TGT_PRG;
                    o_dec.prg_rd = 1'b1;
                end
            end
            CMD_CPU_WR: begin
                if (w_wram) begin
                    o_dec.tgt   = TGT_WRAM;
                    o_dec.wr    = 1'b1;
                    o_dec.maddr = MADDR_W'(i_addr[WIN_W-1:0]);
                    o_dec.wdata = i_wdata;
                end else if (i_addr[15]) begin
                    if ((i_addr & SND_MASK) == SND_DATA) begin
                        o_dec.tgt    = TGT_SOUND;
                        o_dec.wr     = 1'b1;
                        o_dec.wdata  = i_wdata;
                        o_dec.snd_wr = 1'b1;
                    end else begin
                        case (w_sel)
                            REG_PRG0:    o_dec.prg_we     = 3'b001;
                            REG_PRG1:    o_dec.prg_we     = 3'b010;
                            REG_PRG2:    o_dec.prg_we     = 3'b100;
                            REG_SND_IDX: o_dec.snd_idx_we = 1'b1;
                            REG_CHR_A0, REG_CHR_A1, REG_CHR_B0, REG_CHR_B1,
                            REG_CHR_C0, REG_CHR_C1, REG_CHR_D0, REG_CHR_D1:
                                         o_dec.chr_we     = 1'b1;
                            REG_IRQ_RLD: o_dec.irq_rld_we = 1'b1;
                            REG_IRQ_CTL: o_dec.irq_ctl_we = 1'b1;
                            REG_IRQ_ACK: o_dec.irq_ack    = 1'b1;
                            default:     o_dec.irq_ack    = 1'b0;
                        endcase
                    end
                end
            end
            CMD_VID_RD: begin
                if (i_addr[15:13] == 3'b000) begin
                    o_dec.tgt    = TGT_CHR;
                    o_dec.chr_rd = 1'b1;
                end
            end
            CMD_TICK: begin
                o_dec.tick = 1'b1;
            end
            default: begin
                o_dec.tick = 1'b0;
            end
        endcase
    end

endmodule

### rtl/bank_mapper_with_scanline_irq_unit.sv
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq_unit
// Cartridge bank mapper: translates CPU and video accesses, holds the bank,
// sound index and scanline IRQ registers.
// ----------------------------------------------------------------------------
// One bus word is accepted every clock cycle unless the output stalls with
// the middle stage full; the character bank table is a synchronous memory
// read into the middle stage, and an output register behind it lets a new word
// enter while a finished result waits. Bank, sound index and IRQ registers
// update when the word is accepted, so the next word sees them at once. Sound
// data writes leave as target 4 with the register index in mem_addr; the
// sound register file itself lives behind that target. No clearing pass is
// needed after reset: the character bank table reads its reset mapping until
// each entry is first written.
module bank_mapper_with_scanline_irq_unit import bmsi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bmsi_in_if.sink    i_in,
    bmsi_out_if.source o_out,
    bmsi_cfg_if.sink   i_cfg
);

    t_dec                      w_dec;
    logic                      w_acc;
    logic                      w_s1_adv;

    logic [PRG_BANK_W-1:0]     r_last_prg;
    logic [PRG_BANK_W-1:0]     r_prg [3];
    logic [SND_IDX_W-1:0]      r_snd_idx;
    logic [DATA_W-1:0]         r_irq_rld;
    logic [DATA_W-1:0]         r_irq_cnt;
    logic                      r_irq_on;
    logic                      r_irq_flag;
    logic [DATA_W-1:0]         n_irq_cnt;
    logic                      n_irq_on;
    logic                      n_irq_flag;

    logic [CHR_BANK_W-1:0]     r_chr_mem [CHR_BANK_COUNT];
    logic [CHR_BANK_COUNT-1:0] r_chr_vld;
    logic [CHR_BANK_W-1:0]     r_chr_rdata;
    logic                      r_chr_rvld;

    logic [PRG_BANK_W-1:0]     w_prg_bank;
    t_mid                      n_s1;
    t_mid                      r_s1;
    logic                      r_s1_vld;
    logic [CHR_BANK_W-1:0]     w_chr_bank;
    t_res                      n_out;
    t_res                      r_out;
    logic                      r_out_vld;

    bmsi_decode u_decode (
        .i_cmd   (i_in.cmd),
        .i_addr  (i_in.bus_addr),
        .i_wdata (i_in.bus_wdata),
        .o_dec   (w_dec)
    );

    assign w_s1_adv   = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_s1_vld || w_s1_adv;
    assign w_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_irq_cnt  = r_irq_cnt;
        n_irq_on   = r_irq_on;
        n_irq_flag = r_irq_flag;
        if (w_dec.irq_ctl_we) begin
            n_irq_on   = i_in.bus_wdata[IRQ_EN_BIT];
            n_irq_flag = 1'b0;
            if (i_in.bus_wdata[IRQ_EN_BIT]) begin
                n_irq_cnt = r_irq_rld;
            end
        end else if (w_dec.irq_ack) begin
            n_irq_flag = 1'b0;
        end else if (w_dec.tick && r_irq_on) begin
            if (r_irq_cnt == IRQ_CNT_TOP) begin
                n_irq_cnt  = r_irq_rld;
                n_irq_flag = 1'b1;
            end else begin
                n_irq_cnt = r_irq_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_prg <= LAST_PRG_RST;
            r_prg[0]   <= PRG_BANK_W'(0);
            r_prg[1]   <= PRG_BANK_W'(1);
            r_prg[2]   <= PRG_BANK_W'(2);
            r_snd_idx  <= '0;
            r_irq_rld  <= '0;
            r_irq_cnt  <= '0;
            r_irq_on   <= 1'b0;
            r_irq_flag <= 1'b0;
            r_chr_vld  <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_last_prg <= i_cfg.last_prg_bank;
            end
            if (w_acc) begin
                for (int k = 0; k < 3; k++) begin
                    if (w_dec.prg_we[k]) begin
                        r_prg[k] <= i_in.bus_wdata[PRG_BANK_W-1:0];
                    end
                end
                if (w_dec.snd_idx_we) begin
                    r_snd_idx <= i_in.bus_wdata[SND_IDX_W-1:0];
                end
                if (w_dec.irq_rld_we) begin
                    r_irq_rld <= i_in.bus_wdata;
                end
                if (w_dec.chr_we) begin
                    r_chr_vld[w_dec.chr_widx] <= 1'b1;
                end
                r_irq_cnt  <= n_irq_cnt;
                r_irq_on   <= n_irq_on;
                r_irq_flag <= n_irq_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_dec.chr_we) begin
            r_chr_mem[w_dec.chr_widx] <= i_in.bus_wdata;
        end
        if (w_acc) begin
            r_chr_rdata <= r_chr_mem[w_dec.chr_ridx];
            r_chr_rvld  <= r_chr_vld[w_dec.chr_ridx];
        end
    end

    always_comb begin
        case (w_dec.prg_slot)
            2'd0:    w_prg_bank = r_prg[0];
            2'd1:    w_prg_bank = r_prg[1];
            2'd2:    w_prg_bank = r_prg[2];
            default: w_prg_bank = r_last_prg;
        endcase
        n_s1.tgt     = w_dec.tgt;
        n_s1.wr      = w_dec.wr;
        n_s1.maddr   = w_dec.maddr;
        n_s1.wdata   = w_dec.wdata;
        n_s1.irq     = n_irq_flag;
        n_s1.chr_rd  = w_dec.chr_rd;
        n_s1.chr_idx = w_dec.chr_ridx;
        n_s1.chr_ofs = w_dec.chr_ofs;
        if (w_dec.prg_rd) begin
            n_s1.maddr = {w_prg_bank, i_in.bus_addr[WIN_W-1:0]};
        end else if (w_dec.snd_wr) begin
            n_s1.maddr = MADDR_W'(r_snd_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1 <= n_s1;
        end
    end

    assign w_chr_bank = r_chr_rvld ? r_chr_rdata : CHR_BANK_W'(r_s1.chr_idx);

    always_comb begin
        n_out.tgt   = r_s1.tgt;
        n_out.wr    = r_s1.wr;
        n_out.maddr = r_s1.maddr;
        n_out.wdata = r_s1.wdata;
        n_out.irq   = r_s1.irq;
        if (r_s1.chr_rd) begin
            n_out.maddr = MADDR_W'({w_chr_bank, r_s1.chr_ofs});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.target    = r_out.tgt;
    assign o_out.is_write  = r_out.wr;
    assign o_out.mem_addr  = r_out.maddr;
    assign o_out.mem_wdata = r_out.wdata;
    assign o_out.irq       = r_out.irq;

`ifndef SYNTHESIS
    a_ack_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (w_dec.irq_ack || w_dec.irq_ctl_we) |=> !r_irq_flag)
        else $error("irq flag not cleared by acknowledge");

    a_tick_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_dec.tick && r_irq_on && (r_irq_cnt == IRQ_CNT_TOP)
        |=> r_irq_flag && (r_irq_cnt == $past(r_irq_rld)))
        else $error("scanline counter wrap did not reload and raise irq");

    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !w_s1_adv |=> r_s1_vld && $stable(r_s1))
        else $error("middle stage lost or changed a stalled word");

    a_sound_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.tgt == TGT_SOUND) |-> r_out.wr)
        else $error("sound register access without write");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_vld |-> i_in.ready)
        else $error("input stalled with empty pipeline");
`endif

endmodule
